[rtl/lcir_pkg.sv]
package lcir_pkg;

  localparam int unsigned SampleW  = 10;
  localparam int unsigned GainW    = 8;
  localparam int unsigned PhaseW   = 8;
  localparam int unsigned ClampW   = 8;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  // signed error times 9-bit gain
  localparam int unsigned ProdW    = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN          = 3'd0,
    CFG_SP_HIGH       = 3'd1,
    CFG_SP_MID        = 3'd2,
    CFG_SP_LOW        = 3'd3,
    CFG_PULSE_PERIOD  = 3'd4,
    CFG_REG_START     = 3'd5,
    CFG_CLAMP_PULSED  = 3'd6,
    CFG_CLAMP_STEADY  = 3'd7
  } cfg_idx_e;

  localparam logic [GainW-1:0]   GainRst   = 8'd10;
  localparam logic [SampleW-1:0] SpHighRst = 10'd186;
  localparam logic [SampleW-1:0] SpMidRst  = 10'd93;
  localparam logic [SampleW-1:0] SpLowRst  = 10'd47;
  localparam logic [PhaseW-1:0]  PeriodRst = 8'd250;
  localparam logic [PhaseW-1:0]  StartRst  = 8'd230;

  localparam int unsigned ClampPulsedRst    = 200;
  localparam int unsigned ClampSteadyRst    = 186;
  localparam int unsigned IntegralRstFactor = 150;
  localparam int unsigned ClampMax          = 255;

  localparam logic [DutyW-1:0]  DutyFull  = 8'hFF;
  localparam logic [LevelW-1:0] LevelLast = 2'd2;

endpackage

[rtl/led_current_integral_regulator_unit.sv]
// LED current regulator: integral controller with clamp, one item per control tick.
// Input channel: current_sample_i, level_button_i, mode_button_i under in_valid_i;
// an item is taken at a clock edge with in_valid_i high and in_stall_o low.
// Output channel: duty_o, level_index_o, run_mode_o under out_valid_o; the item
// leaves at an edge with out_valid_o high and out_stall_i low.
// Configuration: cfg_valid_i with cfg_index_i and cfg_data_i, always ready;
// write only while no item is in flight.
// Throughput is one item per cycle while the receiver does not stall. An accepted
// item passes the input register, the state update (error times gain, accumulate,
// clamp) into the middle register, then the ceiling divide of the integral, done
// as one multiply by a reciprocal, into the output register behind out_valid_o.
// When the receiver stalls, each stage holds its item; in_stall_o rises only
// once all three stages are full and out_stall_i is high.
// Reset (rst_ni low) empties the pipeline, restores the register defaults and
// sets the integral to 150 duty units, level high, pulsed mode, phase zero.
module led_current_integral_regulator_unit #(
  parameter int unsigned HOLD_TICKS = 20,
  parameter int unsigned SCALE      = 465
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lcir_pkg::SampleW-1:0]  current_sample_i,
  input  logic                          level_button_i,
  input  logic                          mode_button_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lcir_pkg::DutyW-1:0]    duty_o,
  output logic [lcir_pkg::LevelW-1:0]   level_index_o,
  output logic                          run_mode_o,

  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcir_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lcir_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AccW   = $clog2(lcir_pkg::ClampMax * SCALE + 1);
  localparam int unsigned SumW   = ((AccW > lcir_pkg::ProdW) ? AccW : lcir_pkg::ProdW) + 1;
  localparam int unsigned HcntW  = $clog2(HOLD_TICKS + 1);
  localparam int unsigned DivN   = $clog2(256 * SCALE);
  localparam int unsigned DivS   = DivN + $clog2(SCALE);
  localparam int unsigned DivPW  = 2 * DivN + 1;

  localparam logic [DivN:0] Recip =
    (DivN+1)'(((longint'(1) << DivS) + longint'(SCALE) - 1) / longint'(SCALE));
  localparam logic signed [SumW-1:0] ScaleS   = SumW'(SCALE);
  localparam logic [AccW-1:0]        ScaleAcc = AccW'(SCALE);
  localparam logic [AccW-1:0]        AccMax   = AccW'(lcir_pkg::ClampMax * SCALE);
  localparam logic [HcntW-1:0]       HoldCnt  = HcntW'(HOLD_TICKS);

  // configuration
  logic [lcir_pkg::GainW-1:0]   gain_q;
  logic [lcir_pkg::SampleW-1:0] sp_high_q, sp_mid_q, sp_low_q;
  logic [lcir_pkg::PhaseW-1:0]  period_q, start_q;
  logic [AccW-1:0]              lim_pulsed_q, lim_steady_q;
  logic [AccW-1:0]              lim_wr;

  assign cfg_ready_o = 1'b1;
  assign lim_wr      = AccW'(cfg_data_i[lcir_pkg::ClampW-1:0] * SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= lcir_pkg::GainRst;
      sp_high_q    <= lcir_pkg::SpHighRst;
      sp_mid_q     <= lcir_pkg::SpMidRst;
      sp_low_q     <= lcir_pkg::SpLowRst;
      period_q     <= lcir_pkg::PeriodRst;
      start_q      <= lcir_pkg::StartRst;
      lim_pulsed_q <= AccW'(lcir_pkg::ClampPulsedRst * SCALE);
      lim_steady_q <= AccW'(lcir_pkg::ClampSteadyRst * SCALE);
    end else if (cfg_valid_i) begin
      case (lcir_pkg::cfg_idx_e'(cfg_index_i))
        lcir_pkg::CFG_GAIN:         gain_q       <= cfg_data_i[lcir_pkg::GainW-1:0];
        lcir_pkg::CFG_SP_HIGH:      sp_high_q    <= cfg_data_i;
        lcir_pkg::CFG_SP_MID:       sp_mid_q     <= cfg_data_i;
        lcir_pkg::CFG_SP_LOW:       sp_low_q     <= cfg_data_i;
        lcir_pkg::CFG_PULSE_PERIOD: period_q     <= cfg_data_i[lcir_pkg::PhaseW-1:0];
        lcir_pkg::CFG_REG_START:    start_q      <= cfg_data_i[lcir_pkg::PhaseW-1:0];
        lcir_pkg::CFG_CLAMP_PULSED: lim_pulsed_q <= lim_wr;
        lcir_pkg::CFG_CLAMP_STEADY: lim_steady_q <= lim_wr;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic in_vld_q, mid_vld_q, out_vld_q;
  logic s3_free, s2_free, s1_free, s1_move, s2_move;

  assign s3_free    = !out_vld_q || !out_stall_i;
  assign s2_move    = mid_vld_q && s3_free;
  assign s2_free    = !mid_vld_q || s3_free;
  assign s1_move    = in_vld_q && s2_free;
  assign s1_free    = !in_vld_q || s2_free;
  assign in_stall_o = !s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free) in_vld_q  <= in_valid_i;
      if (s2_free) mid_vld_q <= s1_move;
      if (s3_free) out_vld_q <= s2_move;
    end
  end

  // input register
  logic [lcir_pkg::SampleW-1:0] sample_q;
  logic                         lvl_btn_q, mode_btn_q;

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      sample_q   <= current_sample_i;
      lvl_btn_q  <= level_button_i;
      mode_btn_q <= mode_button_i;
    end
  end

  // controller state
  logic [AccW-1:0]               integral_q, integral_d;
  logic [lcir_pkg::LevelW-1:0]   level_q, level_d;
  logic                          mode_q, mode_d;
  logic [HcntW-1:0]              lvl_cnt_q, lvl_cnt_d, mode_cnt_q, mode_cnt_d;
  logic [lcir_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic                          regulate;

  logic [HcntW-1:0]              lvl_inc, mode_inc;
  logic [lcir_pkg::SampleW-1:0]  sp;
  logic signed [lcir_pkg::SampleW:0]    err;
  logic signed [lcir_pkg::ProdW-1:0]    prod;
  logic signed [SumW-1:0]        sum, lo_clip, lim_ext, hi_clip;
  logic [AccW-1:0]               lim_sel;
  logic [lcir_pkg::PhaseW:0]     phase_inc;

  always_comb begin
    lvl_inc    = lvl_cnt_q + HcntW'(1);
    mode_inc   = mode_cnt_q + HcntW'(1);
    lvl_cnt_d  = lvl_cnt_q;
    mode_cnt_d = mode_cnt_q;
    level_d    = level_q;
    mode_d     = mode_q;

    if (lvl_btn_q) begin
      if (lvl_inc == HoldCnt) begin
        lvl_cnt_d = '0;
        level_d   = (level_q >= lcir_pkg::LevelLast) ? '0 : level_q + 2'd1;
      end else begin
        lvl_cnt_d = lvl_inc;
      end
    end
    if (mode_btn_q) begin
      if (mode_inc == HoldCnt) begin
        mode_cnt_d = '0;
        mode_d     = !mode_q;
      end else begin
        mode_cnt_d = mode_inc;
      end
    end

    // steady mode regulates every tick; pulsed mode only inside the window
    phase_inc = {1'b0, phase_q} + 9'd1;
    phase_d   = phase_q;
    regulate  = 1'b0;
    if (mode_d) begin
      regulate = 1'b1;
    end else if (phase_q >= period_q) begin
      phase_d = '0;
    end else begin
      regulate = (phase_q >= start_q);
      phase_d  = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[lcir_pkg::PhaseW-1:0];
    end

    case (level_d)
      2'd0:    sp = sp_high_q;
      2'd1:    sp = sp_mid_q;
      default: sp = sp_low_q;
    endcase

    err     = $signed({1'b0, sp}) - $signed({1'b0, sample_q});
    prod    = err * $signed({1'b0, gain_q});
    sum     = $signed({{(SumW-AccW){1'b0}}, integral_q})
              + $signed({{(SumW-lcir_pkg::ProdW){prod[lcir_pkg::ProdW-1]}}, prod});
    lim_sel = mode_d ? lim_steady_q : lim_pulsed_q;
    lim_ext = $signed({{(SumW-AccW){1'b0}}, lim_sel});
    // floor at one duty unit first, then the upper limit
    lo_clip = (sum <= ScaleS) ? ScaleS : sum;
    hi_clip = (lo_clip > lim_ext) ? lim_ext : lo_clip;
    integral_d = regulate ? hi_clip[AccW-1:0] : integral_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integral_q <= AccW'(lcir_pkg::IntegralRstFactor * SCALE);
      level_q    <= '0;
      mode_q     <= 1'b0;
      lvl_cnt_q  <= '0;
      mode_cnt_q <= '0;
      phase_q    <= '0;
    end else if (s1_move) begin
      integral_q <= integral_d;
      level_q    <= level_d;
      mode_q     <= mode_d;
      lvl_cnt_q  <= lvl_cnt_d;
      mode_cnt_q <= mode_cnt_d;
      phase_q    <= phase_d;
    end
  end

  // middle register
  logic [AccW-1:0]             mid_acc_q;
  logic                        mid_reg_q;
  logic [lcir_pkg::LevelW-1:0] mid_level_q;
  logic                        mid_mode_q;

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      mid_acc_q   <= integral_d;
      mid_reg_q   <= regulate;
      mid_level_q <= level_d;
      mid_mode_q  <= mode_d;
    end
  end

  // ceiling divide by SCALE through a reciprocal multiply
  logic [DivN-1:0]           div_x;
  logic [DivPW-1:0]          div_p;
  logic [lcir_pkg::DutyW-1:0] up;
  logic [lcir_pkg::DutyW-1:0] duty_d;

  always_comb begin
    div_x  = DivN'(mid_acc_q) + DivN'(SCALE - 1);
    div_p  = {{(DivN+1){1'b0}}, div_x} * {{DivN{1'b0}}, Recip};
    up     = div_p[DivS +: lcir_pkg::DutyW];
    duty_d = mid_reg_q ? (lcir_pkg::DutyFull - up) : lcir_pkg::DutyFull;
  end

  // output register
  logic [lcir_pkg::DutyW-1:0]  duty_q;
  logic [lcir_pkg::LevelW-1:0] out_level_q;
  logic                        out_mode_q;

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      duty_q      <= duty_d;
      out_level_q <= mid_level_q;
      out_mode_q  <= mid_mode_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign duty_o        = duty_q;
  assign level_index_o = out_level_q;
  assign run_mode_o    = out_mode_q;

  // checks
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && mid_vld_q && out_vld_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_move_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> mid_vld_q)
    else $error("item lost between input and middle stage");

  a_integral_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integral_q <= AccMax)
    else $error("integral above the largest clamp");

  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lvl_cnt_q < HoldCnt) && (mode_cnt_q < HoldCnt) && (level_q <= lcir_pkg::LevelLast))
    else $error("hold counter or level out of range");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && regulate && (lim_sel >= ScaleAcc)) |=> (integral_q >= ScaleAcc))
    else $error("integral below one duty unit after regulation");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned HoldTicks     = 20;
  localparam int unsigned Scale         = 465;
  localparam int unsigned ClkPeriod     = 10;
  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned PhaseItems    = 50;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_BURST, STALL_HEAVY} stall_pattern_e;
  typedef enum int {SEG_HOLD, SEG_NOISE, SEG_QUIET} button_seg_e;

  // Tracks the regulator state tick by tick and holds the outputs still to arrive.
  class lcir_scoreboard;
    typedef struct {
      logic [lcir_pkg::DutyW-1:0]  duty;
      logic [lcir_pkg::LevelW-1:0] level;
      logic                        mode;
    } tick_out_t;

    tick_out_t expected_ticks[$];
    int mismatches;

    logic [lcir_pkg::GainW-1:0]   gain;
    logic [lcir_pkg::SampleW-1:0] sp_high, sp_mid, sp_low;
    logic [lcir_pkg::PhaseW-1:0]  period, reg_start;
    logic [lcir_pkg::ClampW-1:0]  clamp_pulsed, clamp_steady;

    longint                       integral;
    logic [lcir_pkg::LevelW-1:0]  level;
    logic                         mode;
    logic [4:0]                   level_hold, mode_hold;
    logic [lcir_pkg::PhaseW-1:0]  phase;

    function void reset_state();
      gain         = lcir_pkg::GainRst;
      sp_high      = lcir_pkg::SpHighRst;
      sp_mid       = lcir_pkg::SpMidRst;
      sp_low       = lcir_pkg::SpLowRst;
      period       = lcir_pkg::PeriodRst;
      reg_start    = lcir_pkg::StartRst;
      clamp_pulsed = (lcir_pkg::ClampW)'(lcir_pkg::ClampPulsedRst);
      clamp_steady = (lcir_pkg::ClampW)'(lcir_pkg::ClampSteadyRst);
      integral     = longint'(lcir_pkg::IntegralRstFactor) * Scale;
      level        = '0;
      mode         = 1'b0;
      level_hold   = '0;
      mode_hold    = '0;
      phase        = '0;
      mismatches   = 0;
      expected_ticks.delete();
    endfunction

    function void write_reg(lcir_pkg::cfg_idx_e idx, logic [lcir_pkg::CfgDataW-1:0] data);
      case (idx)
        lcir_pkg::CFG_GAIN:         gain         = data[lcir_pkg::GainW-1:0];
        lcir_pkg::CFG_SP_HIGH:      sp_high      = data[lcir_pkg::SampleW-1:0];
        lcir_pkg::CFG_SP_MID:       sp_mid       = data[lcir_pkg::SampleW-1:0];
        lcir_pkg::CFG_SP_LOW:       sp_low       = data[lcir_pkg::SampleW-1:0];
        lcir_pkg::CFG_PULSE_PERIOD: period       = data[lcir_pkg::PhaseW-1:0];
        lcir_pkg::CFG_REG_START:    reg_start    = data[lcir_pkg::PhaseW-1:0];
        lcir_pkg::CFG_CLAMP_PULSED: clamp_pulsed = data[lcir_pkg::ClampW-1:0];
        lcir_pkg::CFG_CLAMP_STEADY: clamp_steady = data[lcir_pkg::ClampW-1:0];
        default: ;
      endcase
    endfunction

    function logic [lcir_pkg::SampleW-1:0] active_setpoint();
      if (level == 2'd0) return sp_high;
      if (level == 2'd1) return sp_mid;
      return sp_low;
    endfunction

    // accumulate gain * error, clamp to [Scale, clamp * Scale], duty from the ceiling
    function logic [lcir_pkg::DutyW-1:0] integrate(logic [lcir_pkg::SampleW-1:0] sample,
                                                   logic [lcir_pkg::ClampW-1:0] clamp);
      longint err, acc, lim, up;
      err = longint'(active_setpoint()) - longint'(sample);
      acc = integral + err * longint'(gain);
      lim = longint'(clamp) * longint'(Scale);
      if (acc <= longint'(Scale)) acc = longint'(Scale);
      if (acc > lim) acc = lim;
      integral = acc;
      up = (integral + longint'(Scale) - 1) / longint'(Scale);
      return (lcir_pkg::DutyW)'(longint'(lcir_pkg::ClampMax) - up);
    endfunction

    function void note_tick(logic [lcir_pkg::SampleW-1:0] sample, logic lvl_btn, logic mode_btn);
      tick_out_t t;
      t.duty = lcir_pkg::DutyFull;
      if (lvl_btn) begin
        level_hold = level_hold + 5'd1;
        if (level_hold >= HoldTicks) begin
          level_hold = '0;
          level = (level >= lcir_pkg::LevelLast) ? 2'd0 : level + 2'd1;
        end
      end
      if (mode_btn) begin
        mode_hold = mode_hold + 5'd1;
        if (mode_hold >= HoldTicks) begin
          mode_hold = '0;
          mode = ~mode;
        end
      end
      if (mode) begin
        t.duty = integrate(sample, clamp_steady);
      end else if (phase >= period) begin
        // phase left beyond a shortened period: full scale, restart the cycle
        phase = '0;
      end else begin
        if (phase >= reg_start) t.duty = integrate(sample, clamp_pulsed);
        phase = phase + 8'd1;
        if (phase >= period) phase = '0;
      end
      t.level = level;
      t.mode  = mode;
      expected_ticks.push_back(t);
    endfunction

    function void check_output(logic [lcir_pkg::DutyW-1:0] duty,
                               logic [lcir_pkg::LevelW-1:0] lvl, logic run);
      tick_out_t t;
      if (expected_ticks.size() == 0) begin
        $error("unexpected item: duty %0d level_index %0d run_mode %0d", duty, lvl, run);
        mismatches++;
        return;
      end
      t = expected_ticks.pop_front();
      if (duty !== t.duty) begin
        $error("duty: expected %0d, actual %0d", t.duty, duty);
        mismatches++;
      end
      if (lvl !== t.level) begin
        $error("level_index: expected %0d, actual %0d", t.level, lvl);
        mismatches++;
      end
      if (run !== t.mode) begin
        $error("run_mode: expected %0d, actual %0d", t.mode, run);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [lcir_pkg::SampleW-1:0]  current_sample_i;
  logic                          level_button_i;
  logic                          mode_button_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [lcir_pkg::DutyW-1:0]    duty_o;
  logic [lcir_pkg::LevelW-1:0]   level_index_o;
  logic                          run_mode_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [lcir_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [lcir_pkg::CfgDataW-1:0] cfg_data_i;

  lcir_scoreboard                sb;
  logic [lcir_pkg::CfgDataW-1:0] cfg_set [8];
  int                            burst_left;
  bit                            no_gap;
  int                            quiet_cycles;
  stall_pattern_e                stall_mode;
  int                            stall_mode_left;
  int                            stall_run;
  bit                            stall_on;

  // out-of-range phase hit at index 5, then the regulate window, then steady mode
  logic [lcir_pkg::SampleW-1:0] directed_samples [23] = '{
    10'd0, 10'd1023, 10'd512, 10'd1, 10'd1022,
    10'd0,
    10'd0, 10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
    10'd512, 10'd93, 10'd0, 10'd1023, 10'd1, 10'd1022,
    10'd0, 10'd1023, 10'd93
  };

  led_current_integral_regulator_unit #(
    .HOLD_TICKS(HoldTicks),
    .SCALE     (Scale)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .current_sample_i(current_sample_i),
    .level_button_i  (level_button_i),
    .mode_button_i   (mode_button_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .duty_o          (duty_o),
    .level_index_o   (level_index_o),
    .run_mode_o      (run_mode_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int pick_extreme(int lo, int hi);
    int k;
    k = $urandom_range(0, 5);
    if (k == 0) return lo;
    if (k == 1) return hi;
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_item(input logic [lcir_pkg::SampleW-1:0] sample, input logic lb,
                           input logic mb);
    in_valid_i       <= 1'b1;
    current_sample_i <= sample;
    level_button_i   <= lb;
    mode_button_i    <= mb;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(sample, lb, mb);
  endtask

  // send in bursts of random length, with random gaps in between
  task automatic feed(input logic [lcir_pkg::SampleW-1:0] sample, input logic lb,
                      input logic mb);
    int gap;
    if (burst_left == 0) begin
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    send_item(sample, lb, mb);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_cfg();
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= lcir_pkg::cfg_idx_e'(i);
      cfg_data_i  <= cfg_set[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(lcir_pkg::cfg_idx_e'(i), cfg_set[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stall, switching between patterns of its own
  initial begin
    out_stall_i     <= 1'b0;
    stall_mode      = STALL_NONE;
    stall_mode_left = 0;
    stall_run       = 0;
    stall_on        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_mode_left == 0) begin
        stall_mode      = stall_pattern_e'($urandom_range(0, 3));
        stall_mode_left = $urandom_range(100, 400);
      end
      stall_mode_left--;
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_BURST: begin
          if (stall_run == 0) begin
            stall_on  = !stall_on;
            stall_run = stall_on ? $urandom_range(1, 12) : $urandom_range(1, 20);
          end
          stall_run--;
          out_stall_i <= stall_on;
        end
        default:     out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_output(duty_o, level_index_o, run_mode_o);
    end
  end

  // end the run when no channel has moved an item for too long
  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("** led_current_integral_regulator_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int                 k;
    int                 v;
    int                 period;
    int                 seg_left;
    button_seg_e        seg_kind;
    logic               seg_lb;
    logic               seg_mb;
    logic               lb;
    logic               mb;

    sb = new();
    sb.reset_state();
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    current_sample_i <= '0;
    level_button_i   <= 1'b0;
    mode_button_i    <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    burst_left       = 0;
    no_gap           = 1'b0;
    seg_left         = 0;
    seg_kind         = SEG_QUIET;
    seg_lb           = 1'b0;
    seg_mb           = 1'b0;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: both buttons held for the first 20 items to step level and mode
    for (int i = 0; i < 23; i++) begin
      if (i == 5) begin
        drain_results();
        cfg_set[lcir_pkg::CFG_GAIN]         = 10'd255;
        cfg_set[lcir_pkg::CFG_SP_HIGH]      = lcir_pkg::SpHighRst;
        cfg_set[lcir_pkg::CFG_SP_MID]       = lcir_pkg::SpMidRst;
        cfg_set[lcir_pkg::CFG_SP_LOW]       = lcir_pkg::SpLowRst;
        cfg_set[lcir_pkg::CFG_PULSE_PERIOD] = 10'd4;
        cfg_set[lcir_pkg::CFG_REG_START]    = 10'd2;
        cfg_set[lcir_pkg::CFG_CLAMP_PULSED] = 10'd255;
        cfg_set[lcir_pkg::CFG_CLAMP_STEADY] =
          (lcir_pkg::CfgDataW)'(lcir_pkg::ClampSteadyRst);
        program_cfg();
      end
      feed(directed_samples[i], i < 20, i < 20);
    end

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      if (p == 0) begin
        cfg_set[lcir_pkg::CFG_GAIN]         = 10'd0;
        cfg_set[lcir_pkg::CFG_SP_HIGH]      = 10'd0;
        cfg_set[lcir_pkg::CFG_SP_MID]       = 10'd0;
        cfg_set[lcir_pkg::CFG_SP_LOW]       = 10'd0;
        cfg_set[lcir_pkg::CFG_PULSE_PERIOD] = 10'd2;
        cfg_set[lcir_pkg::CFG_REG_START]    = 10'd0;
        cfg_set[lcir_pkg::CFG_CLAMP_PULSED] = 10'd1;
        cfg_set[lcir_pkg::CFG_CLAMP_STEADY] = 10'd1;
      end else if (p == 1) begin
        cfg_set[lcir_pkg::CFG_GAIN]         = 10'd255;
        cfg_set[lcir_pkg::CFG_SP_HIGH]      = 10'd1023;
        cfg_set[lcir_pkg::CFG_SP_MID]       = 10'd1023;
        cfg_set[lcir_pkg::CFG_SP_LOW]       = 10'd1023;
        cfg_set[lcir_pkg::CFG_PULSE_PERIOD] = 10'd255;
        cfg_set[lcir_pkg::CFG_REG_START]    = 10'd254;
        cfg_set[lcir_pkg::CFG_CLAMP_PULSED] = 10'd255;
        cfg_set[lcir_pkg::CFG_CLAMP_STEADY] = 10'd255;
      end else begin
        period = ($urandom_range(0, 1) == 1) ? $urandom_range(2, 32) : pick_extreme(2, 255);
        cfg_set[lcir_pkg::CFG_GAIN]         = (lcir_pkg::CfgDataW)'(pick_extreme(0, 255));
        cfg_set[lcir_pkg::CFG_SP_HIGH]      = (lcir_pkg::CfgDataW)'(pick_extreme(0, 1023));
        cfg_set[lcir_pkg::CFG_SP_MID]       = (lcir_pkg::CfgDataW)'(pick_extreme(0, 1023));
        cfg_set[lcir_pkg::CFG_SP_LOW]       = (lcir_pkg::CfgDataW)'(pick_extreme(0, 1023));
        cfg_set[lcir_pkg::CFG_PULSE_PERIOD] = (lcir_pkg::CfgDataW)'(period);
        // a start beyond the period leaves pulsed mode at full scale
        cfg_set[lcir_pkg::CFG_REG_START]    = ($urandom_range(0, 3) != 0) ?
          (lcir_pkg::CfgDataW)'($urandom_range(0, period - 1)) :
          (lcir_pkg::CfgDataW)'($urandom_range(0, 254));
        cfg_set[lcir_pkg::CFG_CLAMP_PULSED] = (lcir_pkg::CfgDataW)'(pick_extreme(1, 255));
        cfg_set[lcir_pkg::CFG_CLAMP_STEADY] = (lcir_pkg::CfgDataW)'(pick_extreme(1, 255));
      end
      program_cfg();
      no_gap     = ($urandom_range(0, 3) == 0);
      burst_left = 0;

      for (int n = 0; n < PhaseItems; n++) begin
        // hold the sender until every result is back
        if (n == PhaseItems / 2) drain_results();

        if (seg_left == 0) begin
          k = $urandom_range(0, 3);
          if (k < 2) begin
            seg_kind = SEG_HOLD;
            seg_left = $urandom_range(20, 26);
            k        = $urandom_range(0, 2);
            seg_lb   = (k != 1);
            seg_mb   = (k != 0);
          end else begin
            seg_kind = (k == 2) ? SEG_NOISE : SEG_QUIET;
            seg_left = $urandom_range(5, 30);
          end
        end
        seg_left--;
        case (seg_kind)
          SEG_HOLD: begin
            lb = seg_lb;
            mb = seg_mb;
          end
          SEG_NOISE: begin
            lb = ($urandom_range(0, 5) == 0);
            mb = ($urandom_range(0, 5) == 0);
          end
          default: begin
            lb = 1'b0;
            mb = 1'b0;
          end
        endcase

        // mostly near the active target so the loop settles, with extremes mixed in
        k = $urandom_range(0, 7);
        if (k < 4) begin
          v = int'(sb.active_setpoint()) + int'($urandom_range(0, 24)) - 12;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
        end else if (k < 6) begin
          v = $urandom_range(0, 1023);
        end else if (k == 6) begin
          v = 0;
        end else begin
          v = 1023;
        end
        feed((lcir_pkg::SampleW)'(v), lb, mb);
      end
    end

    drain_results();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** led_current_integral_regulator_unit: PASSED **");
    end else begin
      $display("** led_current_integral_regulator_unit: FAILED **");
    end
    $finish;
  end

endmodule
